// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CWDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CWDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/cwdc_pkg.sv =====
// ----------------------------------------------------------------------------
// cwdc_pkg
// Shared constants, register codes and types of the chroma centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwdc_pkg;

	localparam int MAX_ROW_MACROPIXELS_DEF = 256;
	localparam int MAX_ROWS_DEF            = 256;

	localparam int DATA_W     = 8;   // chroma byte
	localparam int SQ_W       = 16;  // one squared difference
	localparam int WEIGHT_W   = 17;  // sum of two squares
	localparam int ROW_MP_W   = 9;   // row_macropixels register
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int CX_W       = 10;
	localparam int CY_W       = 9;

	localparam logic [DATA_W-1:0]   U_CENTER_RST = 8'd157;
	localparam logic [DATA_W-1:0]   U_HALF_RST   = 8'd20;
	localparam logic [DATA_W-1:0]   V_CENTER_RST = 8'd110;
	localparam logic [DATA_W-1:0]   V_HALF_RST   = 8'd25;
	localparam logic [ROW_MP_W-1:0] ROW_MP_RST   = 9'd160;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_U_CENTER = 3'd0,
		REG_U_HALF   = 3'd1,
		REG_V_CENTER = 3'd2,
		REG_V_HALF   = 3'd3,
		REG_ROW_MP   = 3'd4
	} cfg_reg_e;

	typedef struct packed {
		logic [DATA_W-1:0]   u_center;
		logic [DATA_W-1:0]   u_half;
		logic [DATA_W-1:0]   v_center;
		logic [DATA_W-1:0]   v_half;
		logic [ROW_MP_W-1:0] row_mp;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cwdc_ifs.sv =====
// ----------------------------------------------------------------------------
// cwdc_ifs
// Valid/ready channels: macropixel items in, centroid items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwdc_in_if;
	import cwdc_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] cam_u;
	logic [DATA_W-1:0] cam_v;
	logic [DATA_W-1:0] ref_u;
	logic [DATA_W-1:0] ref_v;
	logic              frame_end;

	modport source (output valid, cam_u, cam_v, ref_u, ref_v, frame_end, input ready);
	modport sink   (input valid, cam_u, cam_v, ref_u, ref_v, frame_end, output ready);
endinterface

interface cwdc_out_if;
	import cwdc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   found;
	logic signed [CX_W-1:0] center_x;
	logic signed [CY_W-1:0] center_y;

	modport source (output valid, found, center_x, center_y, input ready);
	modport sink   (input valid, found, center_x, center_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/chroma_window_diff_centroid.sv =====
// ----------------------------------------------------------------------------
// chroma_window_diff_centroid
// Throughput: one macropixel item per cycle while no frame total waits for queue
// room; config registers reset to defaults. Results come from the shared
// bit-serial divider (QW = counter width, 8 by default).
// Frames shorter than the divide time stall input once the two-entry queue fills.
// Reset clears counters, accumulators, queue and output; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module chroma_window_diff_centroid #(
	parameter int MAX_ROW_MACROPIXELS = cwdc_pkg::MAX_ROW_MACROPIXELS_DEF,
	parameter int MAX_ROWS            = cwdc_pkg::MAX_ROWS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	cwdc_in_if.sink                         in_ch,
	cwdc_out_if.source                      out_ch,
	input  wire                             cfg_we,
	input  wire [cwdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [cwdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cwdc_pkg::*;

	localparam int CW     = $clog2(MAX_ROW_MACROPIXELS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int QW     = (CW > RW) ? CW : RW;
	localparam int WSUM_W = WEIGHT_W + CW + RW + 1;
	localparam int MOM_W  = WSUM_W + QW;
	// one queue entry: weight sum, column moment, row moment
	localparam int ENT_W  = WSUM_W + 2 * MOM_W;

	cfg_t cfg_q;

	logic             fq_valid, fq_ready;
	logic [ENT_W-1:0] fq_data;
	logic             qb_valid, qb_ready;
	logic [ENT_W-1:0] qb_data;

	// Config writes must land only while idle (the block does not enforce this), so no shadowing is needed.
	// Indexes past the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.u_center <= U_CENTER_RST;
			cfg_q.u_half   <= U_HALF_RST;
			cfg_q.v_center <= V_CENTER_RST;
			cfg_q.v_half   <= V_HALF_RST;
			cfg_q.row_mp   <= ROW_MP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_U_CENTER: cfg_q.u_center <= cfg_data[DATA_W-1:0];
				REG_U_HALF:   cfg_q.u_half   <= cfg_data[DATA_W-1:0];
				REG_V_CENTER: cfg_q.v_center <= cfg_data[DATA_W-1:0];
				REG_V_HALF:   cfg_q.v_half   <= cfg_data[DATA_W-1:0];
				REG_ROW_MP:   cfg_q.row_mp   <= cfg_data[ROW_MP_W-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// front: window test, weights, moments, accumulation (3 stages + acc)
	cwdc_front #(
		.MAX_ROW_MACROPIXELS(MAX_ROW_MACROPIXELS),
		.MAX_ROWS(MAX_ROWS),
		.ENT_W(ENT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_ch(in_ch),
		.q_valid(fq_valid),
		.q_ready(fq_ready),
		.q_data(fq_data)
	);

	// frame totals wait here while the divider is busy
	cwdc_queue #(
		.W(ENT_W),
		.DEPTH(2)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fq_valid),
		.in_ready(fq_ready),
		.in_data(fq_data),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_data(qb_data)
	);

	// back: two divisions on one shared unit, then the output register
	cwdc_back #(
		.MAX_ROW_MACROPIXELS(MAX_ROW_MACROPIXELS),
		.MAX_ROWS(MAX_ROWS),
		.ENT_W(ENT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(qb_valid),
		.in_ready(qb_ready),
		.in_data(qb_data),
		.out_ch(out_ch)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/cwdc_front.sv =====
// ----------------------------------------------------------------------------
// cwdc_front
// Takes items, tests the chroma windows, forms weights and moments and
// accumulates them; pushes the frame totals on the frame's last item.
// ----------------------------------------------------------------------------
`default_nettype none

module cwdc_front #(
	parameter int MAX_ROW_MACROPIXELS = cwdc_pkg::MAX_ROW_MACROPIXELS_DEF,
	parameter int MAX_ROWS            = cwdc_pkg::MAX_ROWS_DEF,
	parameter int ENT_W               = 118
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire cwdc_pkg::cfg_t cfg,
	cwdc_in_if.sink             in_ch,
	output logic                q_valid,
	input  wire                 q_ready,
	output logic [ENT_W-1:0]    q_data
);
	import cwdc_pkg::*;

	localparam int CW     = $clog2(MAX_ROW_MACROPIXELS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int QW     = (CW > RW) ? CW : RW;
	localparam int WSUM_W = WEIGHT_W + CW + RW + 1;
	localparam int MOM_W  = WSUM_W + QW;
	localparam int CMPW   = (CW + 1 > ROW_MP_W) ? CW + 1 : ROW_MP_W;

	logic adv;
	logic take;

	// position counters
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [CMPW-1:0] width_eff;
	logic            col_wrap;

	// window test and squares
	logic                   u_hit, v_hit;
	logic signed [DATA_W:0] du, dv;
	logic signed [2*DATA_W+1:0] squ, sqv;

	logic                v_s1, hit_s1, last_s1;
	logic [SQ_W-1:0]     squ_s1, sqv_s1;
	logic [CW-1:0]       col_s1;
	logic [RW-1:0]       row_s1;

	logic                v_s2, last_s2;
	logic [WEIGHT_W-1:0] w_s2;
	logic [CW-1:0]       col_s2;
	logic [RW-1:0]       row_s2;

	logic                     v_s3, last_s3;
	logic [WEIGHT_W-1:0]      w_s3;
	logic [WEIGHT_W+CW-1:0]   wc_s3;
	logic [WEIGHT_W+RW-1:0]   wr_s3;

	logic [WSUM_W-1:0] wsum_q, wsum_nxt;
	logic [MOM_W-1:0]  cmom_q, cmom_nxt, rmom_q, rmom_nxt;

	// the whole pipe holds while a frame total waits for queue room
	assign adv         = !(v_s3 && last_s3 && !q_ready);
	assign in_ch.ready = adv;
	assign take        = in_ch.valid && adv;

	always_comb begin
		if (cfg.row_mp == '0) begin
			width_eff = CMPW'(1);
		end else if (CMPW'(cfg.row_mp) > CMPW'(MAX_ROW_MACROPIXELS)) begin
			width_eff = CMPW'(MAX_ROW_MACROPIXELS);
		end else begin
			width_eff = CMPW'(cfg.row_mp);
		end
	end

	assign col_wrap = (CMPW'(col_q) + CMPW'(1)) >= width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (in_ch.frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				if (row_q != RW'(MAX_ROWS - 1)) row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// inclusive windows without wrap: x >= c - h  <=>  x + h >= c
	assign u_hit = ({1'b0, in_ch.cam_u} + {1'b0, cfg.u_half} >= {1'b0, cfg.u_center}) &&
	               ({1'b0, in_ch.cam_u} <= {1'b0, cfg.u_center} + {1'b0, cfg.u_half});
	assign v_hit = ({1'b0, in_ch.cam_v} + {1'b0, cfg.v_half} >= {1'b0, cfg.v_center}) &&
	               ({1'b0, in_ch.cam_v} <= {1'b0, cfg.v_center} + {1'b0, cfg.v_half});

	assign du  = $signed({1'b0, in_ch.cam_u}) - $signed({1'b0, in_ch.ref_u});
	assign dv  = $signed({1'b0, in_ch.cam_v}) - $signed({1'b0, in_ch.ref_v});
	assign squ = du * du;
	assign sqv = dv * dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s1  <= u_hit && v_hit;
			last_s1 <= in_ch.frame_end;
			squ_s1  <= squ[SQ_W-1:0];
			sqv_s1  <= sqv[SQ_W-1:0];
			col_s1  <= col_q;
			row_s1  <= row_q;

			w_s2    <= hit_s1 ? ({1'b0, squ_s1} + {1'b0, sqv_s1}) : '0;
			last_s2 <= last_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;

			w_s3    <= w_s2;
			wc_s3   <= w_s2 * col_s2;
			wr_s3   <= w_s2 * row_s2;
			last_s3 <= last_s2;
		end
	end

	assign wsum_nxt = wsum_q + WSUM_W'(w_s3);
	assign cmom_nxt = cmom_q + MOM_W'(wc_s3);
	assign rmom_nxt = rmom_q + MOM_W'(wr_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			cmom_q <= '0;
			rmom_q <= '0;
		end else if (adv && v_s3) begin
			if (last_s3) begin
				wsum_q <= '0;
				cmom_q <= '0;
				rmom_q <= '0;
			end else begin
				wsum_q <= wsum_nxt;
				cmom_q <= cmom_nxt;
				rmom_q <= rmom_nxt;
			end
		end
	end

	assign q_valid = v_s3 && last_s3;
	assign q_data  = ENT_W'({wsum_nxt, cmom_nxt, rmom_nxt});

endmodule

`default_nettype wire

// ===== hw/rtl/cwdc_queue.sv =====
// ----------------------------------------------------------------------------
// cwdc_queue
// Small flop FIFO of frame totals between accumulation and division.
// ----------------------------------------------------------------------------
`default_nettype none

module cwdc_queue #(
	parameter int W     = 118,
	parameter int DEPTH = 2
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  wire [W-1:0]   in_data,
	output logic          out_valid,
	input  wire           out_ready,
	output logic [W-1:0]  out_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != NW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + NW'(1);
				2'b01:   cnt_q <= cnt_q - NW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cwdc_back.sv =====
// ----------------------------------------------------------------------------
// cwdc_back
// Divides both moments by the weight sum with one shared restoring divider
// and holds the centroid item for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cwdc_back #(
	parameter int MAX_ROW_MACROPIXELS = cwdc_pkg::MAX_ROW_MACROPIXELS_DEF,
	parameter int MAX_ROWS            = cwdc_pkg::MAX_ROWS_DEF,
	parameter int ENT_W               = 118
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire [ENT_W-1:0]   in_data,
	cwdc_out_if.source        out_ch
);
	import cwdc_pkg::*;

	localparam int CW     = $clog2(MAX_ROW_MACROPIXELS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int QW     = (CW > RW) ? CW : RW;
	localparam int SW     = (QW > 1) ? $clog2(QW) : 1;
	localparam int WSUM_W = WEIGHT_W + CW + RW + 1;
	localparam int MOM_W  = WSUM_W + QW;

	typedef enum logic [1:0] {S_IDLE, S_DIVX, S_DIVY, S_HOLD} state_t;

	state_t            state_q;
	logic [WSUM_W-1:0] in_wsum, wsum_q;
	logic [MOM_W-1:0]  in_cmom, in_rmom, rmom_q;
	logic [MOM_W-1:0]  rem_q, dsh_q;
	logic [SW-1:0]     step_q;
	logic [QW-1:0]     qx_q, qy_q;
	logic              found_q;
	logic              bit_ge;
	logic [MOM_W-1:0]  rem_nxt;
	logic              out_load;

	logic                   ovalid_q, ofound_q;
	logic signed [CX_W-1:0] ocx_q;
	logic signed [CY_W-1:0] ocy_q;

	assign in_wsum = in_data[ENT_W-1 -: WSUM_W];
	assign in_cmom = in_data[2*MOM_W-1 -: MOM_W];
	assign in_rmom = in_data[MOM_W-1:0];
	assign in_ready = state_q == S_IDLE;

	// one quotient bit per cycle
	assign bit_ge  = rem_q >= dsh_q;
	assign rem_nxt = bit_ge ? rem_q - dsh_q : rem_q;

	// output register takes a new item when empty or being drained
	assign out_load = (state_q == S_HOLD) && (!ovalid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						wsum_q <= in_wsum;
						rmom_q <= in_rmom;
						rem_q  <= in_cmom;
						dsh_q  <= MOM_W'(in_wsum) << (QW - 1);
						step_q <= SW'(QW - 1);
						qx_q   <= '0;
						qy_q   <= '0;
						found_q <= in_wsum != '0;
						state_q <= (in_wsum != '0) ? S_DIVX : S_HOLD;
					end
				end
				S_DIVX: begin
					qx_q <= QW'({qx_q, bit_ge});
					if (step_q == '0) begin
						rem_q   <= rmom_q;
						dsh_q   <= MOM_W'(wsum_q) << (QW - 1);
						step_q  <= SW'(QW - 1);
						state_q <= S_DIVY;
					end else begin
						rem_q  <= rem_nxt;
						dsh_q  <= dsh_q >> 1;
						step_q <= step_q - SW'(1);
					end
				end
				S_DIVY: begin
					qy_q <= QW'({qy_q, bit_ge});
					rem_q <= rem_nxt;
					dsh_q <= dsh_q >> 1;
					if (step_q == '0) begin
						state_q <= S_HOLD;
					end else begin
						step_q <= step_q - SW'(1);
					end
				end
				S_HOLD: begin
					if (out_load) begin
						ofound_q <= found_q;
						ocx_q    <= found_q ? (CX_W'(qx_q) << 1) : '1;
						ocy_q    <= found_q ? CY_W'(qy_q) : '1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid    = ovalid_q;
	assign out_ch.found    = ofound_q;
	assign out_ch.center_x = ocx_q;
	assign out_ch.center_y = ocy_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cwdc_checker.sv =====
// ----------------------------------------------------------------------------
// cwdc_checker
// Port-level checks on the centroid result items.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cwdc_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire                                found,
	input wire signed [cwdc_pkg::CX_W-1:0]    center_x,
	input wire signed [cwdc_pkg::CY_W-1:0]    center_y
);
	import cwdc_pkg::*;

	`CWDC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(center_x) && $stable(center_y))
	`CWDC_ASSERT_IMP(a_not_found, clk, arst_n, out_valid && !found, center_x == '1 && center_y == '1)
	`CWDC_ASSERT_IMP(a_cx_even, clk, arst_n, out_valid && found, !center_x[0] && !center_x[CX_W-1])
	`CWDC_ASSERT_IMP(a_cy_pos, clk, arst_n, out_valid && found, !center_y[CY_W-1])

endmodule

bind chroma_window_diff_centroid cwdc_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.found(out_ch.found),
	.center_x(out_ch.center_x),
	.center_y(out_ch.center_y)
);

`default_nettype wire
